@@ design/tmsec_pkg.sv @@
package tmsec_pkg;

    localparam int TABLE_WORDS_DEF = 32;

    localparam logic [1:0] VAR_PAIR = 2'd0;
    localparam logic [1:0] VAR_TERM = 2'd1;
    localparam logic [1:0] VAR_SKIP = 2'd2;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    localparam logic [31:0] MARK_A     = 32'h4e5e_4e75;
    localparam logic [31:0] MARK_B     = 32'h4e5d_4e75;
    localparam logic [15:0] RUN_START  = 16'd10;
    localparam logic [15:0] MAX_OFFSET = 16'hffff;
    localparam logic [15:0] MIN_TERM   = 16'd6;
    localparam logic [15:0] MARK_SPAN  = 16'd3;

    // requests from the span logic to the skip table
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_data;
        logic        adv;
        logic        clear;
    } tbl_ctrl_t;

    // table words at the current read position, with presence flags
    typedef struct packed {
        logic        two_words;
        logic        at_ok;
        logic        cnt_ok;
        logic [15:0] limit_word;
        logic [15:0] at_word;
        logic [15:0] cnt_word;
    } tbl_stat_t;

endpackage

@@ design/tmsec_skip_table.sv @@
module tmsec_skip_table
    import tmsec_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  tbl_ctrl_t ctrl,
    output tbl_stat_t stat
);

    localparam int AW    = $clog2(TABLE_WORDS);
    localparam int FW    = $clog2(TABLE_WORDS + 1);
    localparam int DEPTH = 1 << AW;

    logic [15:0]   mem [0:DEPTH-1];
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] read_reg, read_next;
    logic [15:0]   limit_reg;
    logic [15:0]   at_word_reg, cnt_word_reg;
    logic          wr_go;
    logic [AW-1:0] waddr, ra, rb;
    logic [FW:0]   ra_full, rb_full, idx_a, idx_b;

    assign wr_go = ctrl.wr_en && (fill_reg < FW'(TABLE_WORDS));
    assign waddr = fill_reg[AW-1:0];

    always_comb begin
        fill_next = fill_reg;
        read_next = read_reg;
        if (ctrl.clear) begin
            fill_next = '0;
            read_next = '0;
        end else begin
            if (wr_go) begin
                fill_next = fill_reg + FW'(1);
            end
            if (ctrl.adv) begin
                read_next = read_reg + FW'(2);
            end
        end
    end

    // prefetch the two words that the next cycle's read position needs
    assign ra_full = (FW+1)'(read_next) + (FW+1)'(1);
    assign rb_full = (FW+1)'(read_next) + (FW+1)'(2);
    assign ra      = ra_full[AW-1:0];
    assign rb      = rb_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            read_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            read_reg <= read_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_go) begin
            mem[waddr] <= ctrl.wr_data;
        end
        if (wr_go && fill_reg == FW'(0)) begin
            limit_reg <= ctrl.wr_data;
        end
        // forward a word written in the same cycle
        at_word_reg  <= (wr_go && waddr == ra) ? ctrl.wr_data : mem[ra];
        cnt_word_reg <= (wr_go && waddr == rb) ? ctrl.wr_data : mem[rb];
    end

    assign idx_a = (FW+1)'(read_reg) + (FW+1)'(1);
    assign idx_b = (FW+1)'(read_reg) + (FW+1)'(2);

    assign stat.two_words  = fill_reg >= FW'(2);
    assign stat.at_ok      = idx_a < (FW+1)'(fill_reg);
    assign stat.cnt_ok     = idx_b < (FW+1)'(fill_reg);
    assign stat.limit_word = limit_reg;
    assign stat.at_word    = at_word_reg;
    assign stat.cnt_word   = cnt_word_reg;

endmodule

@@ design/three_mode_sum_eor_checksum_unit.sv @@
// Channel  Ports                                              Handshake
// -------  -------------------------------------------------  -----------------
// input    s_mode s_data_byte s_table_word s_last             s_valid / s_ready
// result   m_accepted m_checksum m_consumed                   m_valid / m_ready
// config   variant_wdata                                      variant_we
//
// One item per cycle while s_ready is high: each item is folded into the span
// state in the cycle it is taken; the skip table memory is read from the next
// read position, so its registered words are ready for the following byte.
// A last byte puts its result into a two-slot output (register plus skid);
// s_ready drops only while both slots hold results.
// Reset is synchronous; the table needs no clearing pass, its fill count
// marks which entries hold data.
module three_mode_sum_eor_checksum_unit
    import tmsec_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        variant_we,
    input  logic [1:0]  variant_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_table_word,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [15:0] m_checksum,
    output logic [15:0] m_consumed
);

    logic [1:0]  variant_reg;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  eor_reg, eor_next;
    logic [15:0] run_reg, run_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] offset_reg, offset_next;
    logic [31:0] win_reg, win_next;
    logic        finished_reg, finished_next;
    logic        rejected_reg, rejected_next;
    logic [15:0] found_reg, found_next;
    logic [15:0] skip_rem_reg, skip_rem_next;
    logic [15:0] limit_reg, limit_next;

    logic        out_vld_reg, skid_vld_reg;
    logic        out_acc_reg, skid_acc_reg;
    logic [15:0] out_cs_reg, skid_cs_reg;
    logic [15:0] out_used_reg, skid_used_reg;

    tbl_ctrl_t   tctrl;
    tbl_stat_t   tstat;

    logic        s_fire, byte_go, push, pop, active;
    logic [15:0] p;
    logic [16:0] skip_end;
    logic        res_ok;
    logic [15:0] res_cs, res_used;

    assign s_ready = !skid_vld_reg;
    assign s_fire  = s_valid && s_ready;
    assign byte_go = s_fire && (s_mode == MODE_DATA);
    assign push    = byte_go && s_last;
    assign pop     = out_vld_reg && m_ready;
    assign p       = offset_reg;
    assign skip_end = {1'b0, p} + {1'b0, tstat.cnt_word};

    tmsec_skip_table #(
        .TABLE_WORDS(TABLE_WORDS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tctrl),
        .stat    (tstat)
    );

    always_comb begin
        sum_next      = sum_reg;
        eor_next      = eor_reg;
        run_next      = run_reg;
        acc_next      = acc_reg;
        offset_next   = offset_reg;
        win_next      = win_reg;
        finished_next = finished_reg;
        rejected_next = rejected_reg;
        found_next    = found_reg;
        skip_rem_next = skip_rem_reg;
        limit_next    = limit_reg;
        active        = 1'b0;
        tctrl.wr_en   = s_fire && (s_mode == MODE_TABLE);
        tctrl.wr_data = s_table_word;
        tctrl.adv     = 1'b0;
        tctrl.clear   = 1'b0;

        if (byte_go) begin
            if (p == MAX_OFFSET) begin
                rejected_next = 1'b1;
            end else begin
                offset_next = p + 16'd1;
            end
            active = !rejected_next && !finished_reg;
        end

        if (active) begin
            case (variant_reg)
                VAR_PAIR: begin
                    if (!p[0]) begin
                        sum_next = sum_reg + s_data_byte;
                    end else begin
                        eor_next = eor_reg ^ s_data_byte;
                    end
                end
                VAR_TERM: begin
                    win_next = {win_reg[23:0], s_data_byte};
                    if (p[0] && p >= MARK_SPAN) begin
                        if (win_next == MARK_A || win_next == MARK_B) begin
                            if (p == MARK_SPAN) begin
                                rejected_next = 1'b1;
                            end else begin
                                finished_next = 1'b1;
                                found_next    = p - MARK_SPAN;
                            end
                        end else begin
                            run_next = run_reg + win_next[31:16];
                            acc_next = acc_reg ^ run_next;
                        end
                    end
                end
                VAR_SKIP: begin
                    if (!tstat.two_words) begin
                        rejected_next = 1'b1;
                    end else begin
                        limit_next = tstat.limit_word;
                        if (limit_next == 16'd0) begin
                            rejected_next = 1'b1;
                        end else if (p >= limit_next) begin
                            // past the limit: drop the byte
                        end else if (skip_rem_reg != 16'd0) begin
                            skip_rem_next = skip_rem_reg - 16'd1;
                        end else if (!tstat.at_ok) begin
                            rejected_next = 1'b1;
                        end else if (tstat.at_word == p) begin
                            if (!tstat.cnt_ok) begin
                                rejected_next = 1'b1;
                            end else begin
                                tctrl.adv = 1'b1;
                                if (tstat.cnt_word == 16'd0 ||
                                    skip_end > {1'b0, limit_next}) begin
                                    rejected_next = 1'b1;
                                end else begin
                                    skip_rem_next = tstat.cnt_word - 16'd1;
                                end
                            end
                        end else begin
                            acc_next = (acc_reg + {8'd0, s_data_byte}) ^ (p + 16'd1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res_ok   = 1'b0;
        res_cs   = 16'd0;
        res_used = 16'd0;
        if (!rejected_next) begin
            case (variant_reg)
                VAR_PAIR: begin
                    if (!offset_next[0]) begin
                        res_ok   = 1'b1;
                        res_cs   = {sum_next, eor_next};
                        res_used = offset_next;
                    end
                end
                VAR_TERM: begin
                    if (finished_next && offset_next >= MIN_TERM) begin
                        res_ok   = 1'b1;
                        res_cs   = acc_next;
                        res_used = found_next;
                    end
                end
                VAR_SKIP: begin
                    if (limit_next != 16'd0 && limit_next <= offset_next) begin
                        res_ok   = 1'b1;
                        res_cs   = acc_next;
                        res_used = limit_next;
                    end
                end
                default: begin
                end
            endcase
        end

        // end of span: clear all span state, table included
        if (push) begin
            sum_next      = 8'd0;
            eor_next      = 8'd0;
            run_next      = RUN_START;
            acc_next      = 16'd0;
            offset_next   = 16'd0;
            win_next      = 32'd0;
            finished_next = 1'b0;
            rejected_next = 1'b0;
            found_next    = 16'd0;
            skip_rem_next = 16'd0;
            limit_next    = 16'd0;
            tctrl.clear   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg  <= VAR_PAIR;
            sum_reg      <= 8'd0;
            eor_reg      <= 8'd0;
            run_reg      <= RUN_START;
            acc_reg      <= 16'd0;
            offset_reg   <= 16'd0;
            win_reg      <= 32'd0;
            finished_reg <= 1'b0;
            rejected_reg <= 1'b0;
            found_reg    <= 16'd0;
            skip_rem_reg <= 16'd0;
            limit_reg    <= 16'd0;
        end else begin
            if (variant_we) begin
                variant_reg <= variant_wdata;
            end
            sum_reg      <= sum_next;
            eor_reg      <= eor_next;
            run_reg      <= run_next;
            acc_reg      <= acc_next;
            offset_reg   <= offset_next;
            win_reg      <= win_next;
            finished_reg <= finished_next;
            rejected_reg <= rejected_next;
            found_reg    <= found_next;
            skip_rem_reg <= skip_rem_next;
            limit_reg    <= limit_next;
        end
    end

    // output register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_vld_reg && !pop) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_acc_reg  <= skid_acc_reg;
                out_cs_reg   <= skid_cs_reg;
                out_used_reg <= skid_used_reg;
            end
        end else if (push) begin
            if (out_vld_reg && !pop) begin
                skid_acc_reg  <= res_ok;
                skid_cs_reg   <= res_cs;
                skid_used_reg <= res_used;
            end else begin
                out_acc_reg  <= res_ok;
                out_cs_reg   <= res_cs;
                out_used_reg <= res_used;
            end
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_accepted = out_acc_reg;
    assign m_checksum = out_cs_reg;
    assign m_consumed = out_used_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid slot full while output slot empty");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_checksum == 16'd0 && m_consumed == 16'd0))
        else $error("rejected span carries nonzero fields");

    a_span_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (offset_reg == 16'd0 && !rejected_reg && !finished_reg))
        else $error("span state not cleared after last byte");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("last byte left no result");
`endif

endmodule
